// ----- rtl/core/svm_pkg.sv -----
`default_nettype none

package svm_pkg;

   localparam int ACTION_W = 2;
   localparam int ADDR_W   = 14;
   localparam int LEN_W    = 15;
   localparam int WORD_W   = 16;
   localparam int VOL_W    = 16;
   localparam int SLOT_W   = 3;
   localparam int DRIVE_W  = 16;

   localparam logic [ACTION_W-1:0] ACT_TICK  = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_START = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_WRITE = 2'd2;

   localparam logic [LEN_W-1:0]   LEN_MAX     = 15'd16384;
   localparam logic [DRIVE_W-1:0] DRIVE_UNITY = 16'd256;
   localparam logic [DRIVE_W-1:0] DRIVE_MULT  = 16'd200;
   localparam int DRIVE_FRAC = 40;
   localparam int OUT_SHIFT  = 22;
   localparam int SAT_MAX    = 32767;

   // multiplier digit count and the widest multiplicand of the drive curve
   localparam int MUL_BITS = 16;
   localparam int CFG_MW   = 49;

   typedef struct packed {
      logic start;
   } mul_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } mul_sts_type;

endpackage

`default_nettype wire

// ----- rtl/core/sample_voice_mixer_top.sv -----
// A memory write reduces its address bit-serially; a start scans for a free voice and,
// if one is found, reduces the address bit-serially; a tick reads and multiplies each
// active voice, skips each inactive one, then applies the drive gain; one request at a time.
// The bit-serial multiplier sets most of the time a tick takes. A drive_amount
// write holds off requests while the gain curve is computed.
// Reset clears voice state and the result valid and sets unity gain; sample memory is kept.
`default_nettype none

module sample_voice_mixer_top
   import svm_pkg::*;
#(
   parameter int VOICES       = 8,
   parameter int SAMPLE_WORDS = 16384
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic [ACTION_W-1:0]       req_action,
   input  wire logic [ADDR_W-1:0]         req_mem_address,
   input  wire logic [LEN_W-1:0]          req_sound_length,
   input  wire logic signed [WORD_W-1:0]  req_sample_word,
   input  wire logic                      req_loop_flag,
   input  wire logic [VOL_W-1:0]          req_voice_volume,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic signed [WORD_W-1:0]       rsp_sample_out,
   output logic                           rsp_is_sample,
   output logic                           rsp_started,
   output logic [SLOT_W-1:0]              rsp_voice_slot,
   output logic                           rsp_start_dropped,
   input  wire logic                      csr_write_enable,
   input  wire logic [DRIVE_W-1:0]        csr_write_data
);

   localparam int AW   = $clog2(SAMPLE_WORDS);
   localparam int VIW  = (VOICES > 1) ? $clog2(VOICES) : 1;
   localparam int ACCW = 32 + $clog2(VOICES);
   localparam int MW   = (ACCW > CFG_MW) ? ACCW : CFG_MW;
   localparam int PW   = MW + MUL_BITS;
   localparam int MCW  = $clog2(ADDR_W);

   localparam logic [AW:0]           SW_K    = (AW+1)'(SAMPLE_WORDS);
   localparam logic [AW-1:0]         SW_LAST = AW'(SAMPLE_WORDS - 1);
   localparam logic [VIW-1:0]        V_LAST  = VIW'(VOICES - 1);
   localparam logic [PW-1:0]         CFG_RND = PW'(1) << (DRIVE_FRAC - 1);
   localparam logic signed [PW-1:0]  OUT_RND = PW'(1) << (OUT_SHIFT - 1);
   localparam logic signed [PW-1:0]  SAT_HI  = PW'(SAT_MAX);
   localparam logic signed [PW-1:0]  SAT_LO  = -SAT_HI;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_MOD    = 4'd1;
   localparam logic [3:0] S_WRITE  = 4'd2;
   localparam logic [3:0] S_SCAN   = 4'd3;
   localparam logic [3:0] S_CLAIM  = 4'd4;
   localparam logic [3:0] S_VCHK   = 4'd5;
   localparam logic [3:0] S_VREAD  = 4'd6;
   localparam logic [3:0] S_SREAD  = 4'd7;
   localparam logic [3:0] S_VMUL   = 4'd8;
   localparam logic [3:0] S_DSTART = 4'd9;
   localparam logic [3:0] S_DMUL   = 4'd10;
   localparam logic [3:0] S_CFG1   = 4'd11;
   localparam logic [3:0] S_CFG2   = 4'd12;
   localparam logic [3:0] S_CFG3   = 4'd13;
   localparam logic [3:0] S_RESP   = 4'd14;

   typedef struct packed {
      logic [AW-1:0]     base;
      logic [LEN_W-1:0]  len;
      logic [VOL_W-1:0]  gain;
      logic [ADDR_W-1:0] pos;
      logic [AW-1:0]     cur;
   } vrec_type;

   logic [3:0]               state_ff, state_in;
   logic [ACTION_W-1:0]      act_ff, act_in;
   logic [LEN_W-1:0]         len_ff, len_in;
   logic signed [WORD_W-1:0] word_ff, word_in;
   logic                     lpf_ff, lpf_in;
   logic [VOL_W-1:0]         vol_ff, vol_in;
   logic [VIW-1:0]           vidx_ff, vidx_in;
   logic [VOICES-1:0]        active_ff, active_in;
   logic [VOICES-1:0]        looping_ff, looping_in;
   logic signed [ACCW-1:0]   acc_ff, acc_in;
   logic [AW-1:0]            mod_r_ff, mod_r_in;
   logic [ADDR_W-1:0]        mod_sh_ff, mod_sh_in;
   logic [MCW-1:0]           mod_cnt_ff, mod_cnt_in;
   logic [AW:0]              mod_cat, mod_red;
   logic [DRIVE_W-1:0]       drive_amt_ff, drive_amt_in;
   logic [DRIVE_W-1:0]       drive_gain_ff, drive_gain_in;
   logic signed [WORD_W-1:0] pend_sample_ff, pend_sample_in;
   logic                     pend_started_ff, pend_started_in;
   logic                     pend_drop_ff, pend_drop_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [WORD_W-1:0] rsp_sample_ff;
   logic                     rsp_is_ff, rsp_started_ff, rsp_drop_ff;
   logic [SLOT_W-1:0]        rsp_slot_ff;

   vrec_type                 vrec_mem [VOICES];
   vrec_type                 vrec_rd_ff;
   vrec_type                 vrec_wd;
   logic                     vrec_we;
   logic signed [WORD_W-1:0] sample_mem [SAMPLE_WORDS];
   logic signed [WORD_W-1:0] samp_rd_ff;
   logic                     samp_we, samp_re;

   mul_ctl_type              mul_ctl;
   mul_sts_type              mul_sts;
   logic signed [MW-1:0]     mul_a;
   logic [MUL_BITS-1:0]      mul_b;
   logic signed [PW-1:0]     prod;

   logic [LEN_W-1:0]         len_sat;
   logic [LEN_W-1:0]         pos_nx;
   logic                     pos_wrap;
   logic signed [PW-1:0]     drv_v, drv_q;
   logic [PW-1:0]            cfg_v;
   logic                     accept;
   logic                     slot_free;

   svm_sermul #(
      .MW(MW)
   ) u_mul (
      .clock (clock),
      .reset (reset),
      .ctl   (mul_ctl),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .sts   (mul_sts),
      .prod  (prod)
   );

   assign req_ready = (state_ff == S_IDLE) && !csr_write_enable;
   assign accept    = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   // one address bit per cycle, MSB first, reduced modulo the memory depth
   assign mod_cat = {mod_r_ff, mod_sh_ff[ADDR_W-1]};
   assign mod_red = (mod_cat >= SW_K) ? (mod_cat - SW_K) : mod_cat;

   assign len_sat = (len_ff == '0) ? LEN_W'(1) : ((len_ff > LEN_MAX) ? LEN_MAX : len_ff);
   assign pos_nx   = LEN_W'(vrec_rd_ff.pos) + 1'b1;
   assign pos_wrap = pos_nx >= vrec_rd_ff.len;

   assign drv_v = prod + OUT_RND;
   assign drv_q = drv_v >>> OUT_SHIFT;
   assign cfg_v = prod + CFG_RND;

   // multiplier operand select
   always_comb begin
      mul_ctl.start = 1'b0;
      mul_a         = '0;
      mul_b         = '0;
      if (csr_write_enable) begin
         mul_ctl.start = 1'b1;
         mul_a         = MW'(csr_write_data);
         mul_b         = csr_write_data;
      end else begin
         case (state_ff)
            S_SREAD: begin
               mul_ctl.start = 1'b1;
               mul_a         = MW'(samp_rd_ff);
               mul_b         = vrec_rd_ff.gain;
            end
            S_DSTART: begin
               mul_ctl.start = 1'b1;
               mul_a         = MW'(acc_ff);
               mul_b         = drive_gain_ff;
            end
            S_CFG1: begin
               mul_ctl.start = mul_sts.done;
               mul_a         = MW'(prod[31:0]);
               mul_b         = drive_amt_ff;
            end
            S_CFG2: begin
               mul_ctl.start = mul_sts.done;
               mul_a         = MW'(prod[47:0]);
               mul_b         = DRIVE_MULT;
            end
            default: begin
               mul_ctl.start = 1'b0;
            end
         endcase
      end
   end

   always_comb begin
      state_in        = state_ff;
      act_in          = act_ff;
      len_in          = len_ff;
      word_in         = word_ff;
      lpf_in          = lpf_ff;
      vol_in          = vol_ff;
      vidx_in         = vidx_ff;
      active_in       = active_ff;
      looping_in      = looping_ff;
      acc_in          = acc_ff;
      mod_r_in        = mod_r_ff;
      mod_sh_in       = mod_sh_ff;
      mod_cnt_in      = mod_cnt_ff;
      drive_amt_in    = drive_amt_ff;
      drive_gain_in   = drive_gain_ff;
      pend_sample_in  = pend_sample_ff;
      pend_started_in = pend_started_ff;
      pend_drop_in    = pend_drop_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      vrec_we         = 1'b0;
      vrec_wd         = vrec_rd_ff;
      samp_we         = 1'b0;
      samp_re         = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               act_in          = req_action;
               len_in          = req_sound_length;
               word_in         = req_sample_word;
               lpf_in          = req_loop_flag;
               vol_in          = req_voice_volume;
               vidx_in         = '0;
               acc_in          = '0;
               pend_sample_in  = '0;
               pend_started_in = 1'b0;
               pend_drop_in    = 1'b0;
               mod_r_in        = '0;
               mod_sh_in       = req_mem_address;
               mod_cnt_in      = MCW'(ADDR_W - 1);
               case (req_action)
                  ACT_TICK:  state_in = S_VCHK;
                  ACT_START: state_in = S_SCAN;
                  ACT_WRITE: state_in = S_MOD;
                  default:   state_in = S_RESP;
               endcase
            end
         end
         S_MOD: begin
            mod_r_in   = mod_red[AW-1:0];
            mod_sh_in  = mod_sh_ff << 1;
            mod_cnt_in = mod_cnt_ff - 1'b1;
            if (mod_cnt_ff == '0) begin
               state_in = (act_ff == ACT_WRITE) ? S_WRITE : S_CLAIM;
            end
         end
         S_WRITE: begin
            samp_we  = 1'b1;
            state_in = S_RESP;
         end
         S_SCAN: begin
            if (!active_ff[vidx_ff]) begin
               state_in = S_MOD;
            end else if (vidx_ff == V_LAST) begin
               pend_drop_in = 1'b1;
               state_in     = S_RESP;
            end else begin
               vidx_in = vidx_ff + 1'b1;
            end
         end
         S_CLAIM: begin
            vrec_we               = 1'b1;
            vrec_wd.base          = mod_r_ff;
            vrec_wd.len           = len_sat;
            vrec_wd.gain          = vol_ff;
            vrec_wd.pos           = '0;
            vrec_wd.cur           = mod_r_ff;
            active_in[vidx_ff]    = 1'b1;
            looping_in[vidx_ff]   = lpf_ff;
            pend_started_in       = 1'b1;
            state_in              = S_RESP;
         end
         S_VCHK: begin
            if (active_ff[vidx_ff]) begin
               state_in = S_VREAD;
            end else if (vidx_ff == V_LAST) begin
               state_in = S_DSTART;
            end else begin
               vidx_in = vidx_ff + 1'b1;
            end
         end
         S_VREAD: begin
            samp_re  = 1'b1;
            state_in = S_SREAD;
         end
         S_SREAD: begin
            state_in = S_VMUL;
         end
         S_VMUL: begin
            if (mul_sts.done) begin
               acc_in  = acc_ff + ACCW'(prod);
               vrec_we = 1'b1;
               if (pos_wrap) begin
                  vrec_wd.pos = '0;
                  vrec_wd.cur = vrec_rd_ff.base;
                  if (!looping_ff[vidx_ff]) begin
                     active_in[vidx_ff] = 1'b0;
                  end
               end else begin
                  vrec_wd.pos = pos_nx[ADDR_W-1:0];
                  vrec_wd.cur = (vrec_rd_ff.cur == SW_LAST) ? '0 : (vrec_rd_ff.cur + 1'b1);
               end
               if (vidx_ff == V_LAST) begin
                  state_in = S_DSTART;
               end else begin
                  vidx_in  = vidx_ff + 1'b1;
                  state_in = S_VCHK;
               end
            end
         end
         S_DSTART: begin
            state_in = S_DMUL;
         end
         S_DMUL: begin
            if (mul_sts.done) begin
               if (drv_q > SAT_HI) begin
                  pend_sample_in = WORD_W'(SAT_HI);
               end else if (drv_q < SAT_LO) begin
                  pend_sample_in = WORD_W'(SAT_LO);
               end else begin
                  pend_sample_in = WORD_W'(drv_q);
               end
               state_in = S_RESP;
            end
         end
         S_CFG1: begin
            if (mul_sts.done) begin
               state_in = S_CFG2;
            end
         end
         S_CFG2: begin
            if (mul_sts.done) begin
               state_in = S_CFG3;
            end
         end
         S_CFG3: begin
            if (mul_sts.done) begin
               drive_gain_in = DRIVE_UNITY + cfg_v[DRIVE_FRAC+DRIVE_W-1:DRIVE_FRAC];
               state_in      = S_IDLE;
            end
         end
         S_RESP: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // a drive write restarts the gain curve
      if (csr_write_enable) begin
         drive_amt_in = csr_write_data;
         state_in     = S_CFG1;
      end
   end

   always_ff @(posedge clock) begin
      act_ff          <= act_in;
      len_ff          <= len_in;
      word_ff         <= word_in;
      lpf_ff          <= lpf_in;
      vol_ff          <= vol_in;
      vidx_ff         <= vidx_in;
      acc_ff          <= acc_in;
      mod_r_ff        <= mod_r_in;
      mod_sh_ff       <= mod_sh_in;
      mod_cnt_ff      <= mod_cnt_in;
      drive_amt_ff    <= drive_amt_in;
      pend_sample_ff  <= pend_sample_in;
      pend_started_ff <= pend_started_in;
      pend_drop_ff    <= pend_drop_in;
      if (state_ff == S_RESP && slot_free) begin
         rsp_sample_ff  <= pend_sample_ff;
         rsp_is_ff      <= (act_ff == ACT_TICK);
         rsp_started_ff <= pend_started_ff;
         rsp_slot_ff    <= pend_started_ff ? SLOT_W'(vidx_ff) : '0;
         rsp_drop_ff    <= pend_drop_ff;
      end
      if (reset) begin
         state_ff      <= S_IDLE;
         active_ff     <= '0;
         looping_ff    <= '0;
         drive_gain_ff <= DRIVE_UNITY;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         active_ff     <= active_in;
         looping_ff    <= looping_in;
         drive_gain_ff <= drive_gain_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (vrec_we) begin
         vrec_mem[vidx_ff] <= vrec_wd;
      end
      if (state_ff == S_VCHK) begin
         vrec_rd_ff <= vrec_mem[vidx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (samp_we) begin
         sample_mem[mod_r_ff] <= word_ff;
      end
      if (samp_re) begin
         samp_rd_ff <= sample_mem[vrec_rd_ff.cur];
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_sample_out    = rsp_sample_ff;
   assign rsp_is_sample     = rsp_is_ff;
   assign rsp_started       = rsp_started_ff;
   assign rsp_voice_slot    = rsp_slot_ff;
   assign rsp_start_dropped = rsp_drop_ff;

   a_write_only_for_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WRITE) |-> (act_ff == ACT_WRITE))
      else $error("sample memory write outside a write request");

   a_resp_from_resp_state: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_RESP))
      else $error("response raised outside the response state");

   a_mul_in_wait_state: assert property (@(posedge clock) disable iff (reset)
      (mul_sts.busy || mul_sts.done) |->
         (state_ff == S_VMUL || state_ff == S_DMUL || state_ff == S_CFG1 ||
          state_ff == S_CFG2 || state_ff == S_CFG3))
      else $error("multiplier running while the sequencer is not waiting on it");

   a_started_has_no_drop: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RESP) |-> !(pend_started_ff && pend_drop_ff))
      else $error("start both claimed and dropped");

endmodule

`default_nettype wire

// ----- rtl/core/svm_sermul.sv -----
`default_nettype none

module svm_sermul
   import svm_pkg::*;
#(
   parameter int MW = 49
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire mul_ctl_type                      ctl,
   input  wire logic signed [MW-1:0]             mul_a,
   input  wire logic [MUL_BITS-1:0]              mul_b,
   output mul_sts_type                           sts,
   output logic signed [MW+MUL_BITS-1:0]         prod
);

   localparam int CW = $clog2(MUL_BITS + 1);

   logic signed [MW-1:0]   a_ff;
   logic signed [MW:0]     hi_ff, hi_in;
   logic [MUL_BITS-1:0]    lo_ff, lo_in;
   logic [CW-1:0]          cnt_ff, cnt_in;
   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic signed [MW:0]     sum;

   // one multiplier bit per cycle, LSB first; shift the partial product right
   always_comb begin
      sum     = lo_ff[0] ? (hi_ff + (MW+1)'(a_ff)) : hi_ff;
      hi_in   = hi_ff;
      lo_in   = lo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (ctl.start) begin
         hi_in   = '0;
         lo_in   = mul_b;
         cnt_in  = CW'(MUL_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         hi_in  = sum >>> 1;
         lo_in  = {sum[0], lo_ff[MUL_BITS-1:1]};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.start) begin
         a_ff <= mul_a;
      end
      hi_ff <= hi_in;
      lo_ff <= lo_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign prod     = {hi_ff[MW-1:0], lo_ff};

endmodule

`default_nettype wire
